// File: rtl/marm_pkg.sv
package marm_pkg;

  typedef enum logic [1:0] {
    CMD_ADD_SUBJECT = 2'd0,
    CMD_ADD_OBJECT  = 2'd1,
    CMD_READ        = 2'd2,
    CMD_WRITE       = 2'd3
  } marm_cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DENIED    = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_FULL      = 3'd4
  } marm_status_e;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned ValueW = 32;

  typedef struct packed {
    marm_cmd_e                command;
    logic [KeyW-1:0]          subject_key;
    logic [KeyW-1:0]          object_key;
    logic [1:0]               level;
    logic signed [ValueW-1:0] write_value;
  } marm_in_t;

  typedef struct packed {
    marm_status_e             status;
    logic signed [ValueW-1:0] read_value;
  } marm_out_t;

  // Lookup summary that a name table reports for the key presented to it.
  typedef struct packed {
    logic hit;
    logic full;
  } marm_match_t;

endpackage

// File: rtl/marm_ram.sv
module marm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/marm_table.sv
module marm_table
  import marm_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned LVL_W   = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [KeyW-1:0]            key_i,
  input  logic                       add_i,
  input  logic [LVL_W-1:0]           level_i,
  output marm_match_t                match_o,
  output logic [$clog2(ENTRIES)-1:0] hit_idx_o,
  output logic [LVL_W-1:0]           hit_level_o,
  output logic [$clog2(ENTRIES)-1:0] free_idx_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);

  logic [ENTRIES-1:0] valid_q;
  logic [KeyW-1:0]    name_q  [ENTRIES];
  logic [LVL_W-1:0]   level_q [ENTRIES];
  logic [ENTRIES-1:0] hit_vec;
  logic [IdxW-1:0]    hit_idx;
  logic [LVL_W-1:0]   hit_level;
  logic [IdxW-1:0]    free_idx;

  // Names are unique among valid entries, so at most one bit of hit_vec is set
  // and the index and level can be gathered by OR-ing.
  always_comb begin
    hit_idx   = '0;
    hit_level = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (name_q[i] == key_i);
      if (hit_vec[i]) begin
        hit_idx   = hit_idx | IdxW'(i);
        hit_level = hit_level | level_q[i];
      end
    end
  end

  // Lowest free entry wins.
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (add_i) begin
      valid_q[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (add_i) begin
      name_q[free_idx]  <= key_i;
      level_q[free_idx] <= level_i;
    end
  end

  assign match_o.hit  = |hit_vec;
  assign match_o.full = &valid_q;
  assign hit_idx_o    = hit_idx;
  assign hit_level_o  = hit_level;
  assign free_idx_o   = free_idx;

endmodule

// File: rtl/mandatory_access_reference_monitor.sv
// Channel   Direction  Payload      Handshake
// -------   ---------  -----------  ------------------------------
// in        input      marm_in_t    in_valid_i / in_stall_o
// out       output     marm_out_t   out_valid_o / out_stall_i
//
// Each command beat produces one result beat after it is accepted:
// the name lookup and all table updates happen at the accept edge, and the
// object value RAM registers its read data at that edge.
// A new command can be accepted every cycle while the output side drains.
// Reset clears the valid bits of both name tables; no clearing pass is needed.
// A stalled output holds the result register and, once the lookup stage is
// also full, stalls the input.
module mandatory_access_reference_monitor
  import marm_pkg::*;
#(
  parameter int unsigned SUBJECT_ENTRIES = 16,
  parameter int unsigned OBJECT_ENTRIES  = 16,
  parameter int unsigned LEVEL_COUNT     = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  marm_in_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output marm_out_t out_o
);

  localparam int unsigned LvlW    = $clog2(LEVEL_COUNT);
  localparam int unsigned ObjIdxW = $clog2(OBJECT_ENTRIES);

  logic               accept;
  logic [LvlW-1:0]    add_level;

  marm_match_t        subj_match;
  logic [LvlW-1:0]    subj_level;
  logic               subj_add;

  marm_match_t        obj_match;
  logic [ObjIdxW-1:0] obj_hit_idx;
  logic [ObjIdxW-1:0] obj_free_idx;
  logic [LvlW-1:0]    obj_level;
  logic               obj_add;

  logic               ram_we;
  logic               ram_re;
  logic [ObjIdxW-1:0] ram_addr;
  logic [ValueW-1:0]  ram_wdata;
  logic [ValueW-1:0]  ram_rdata;

  marm_status_e       status;
  logic               grant_read;
  logic               grant_write;

  // Lookup stage: holds the status of an accepted command while the RAM read
  // completes. s1_rd_q marks a granted read whose value comes from the RAM.
  logic               s1_valid_q, s1_valid_d;
  marm_status_e       s1_status_q;
  logic               s1_rd_q;
  logic               s1_move;

  logic               out_valid_q, out_valid_d;
  marm_out_t          out_q;

  assign accept = in_valid_i && !in_stall_o;

  // Add levels beyond the configured range saturate to the top level.
  always_comb begin
    if ({3'b000, in_i.level} >= 5'(LEVEL_COUNT)) begin
      add_level = LvlW'(LEVEL_COUNT - 1);
    end else begin
      add_level = LvlW'(in_i.level);
    end
  end

  marm_table #(
    .ENTRIES (SUBJECT_ENTRIES),
    .LVL_W   (LvlW)
  ) u_subj_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (in_i.subject_key),
    .add_i       (subj_add),
    .level_i     (add_level),
    .match_o     (subj_match),
    .hit_idx_o   (),
    .hit_level_o (subj_level),
    .free_idx_o  ()
  );

  marm_table #(
    .ENTRIES (OBJECT_ENTRIES),
    .LVL_W   (LvlW)
  ) u_obj_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (in_i.object_key),
    .add_i       (obj_add),
    .level_i     (add_level),
    .match_o     (obj_match),
    .hit_idx_o   (obj_hit_idx),
    .hit_level_o (obj_level),
    .free_idx_o  (obj_free_idx)
  );

  // Command decode. The no-read-up and no-write-down rules reduce to one
  // level compare each once both names are found.
  always_comb begin
    status      = ST_OK;
    subj_add    = 1'b0;
    obj_add     = 1'b0;
    grant_read  = 1'b0;
    grant_write = 1'b0;
    case (in_i.command)
      CMD_ADD_SUBJECT: begin
        if (subj_match.hit) begin
          status = ST_DUPLICATE;
        end else if (subj_match.full) begin
          status = ST_FULL;
        end else begin
          subj_add = accept;
        end
      end
      CMD_ADD_OBJECT: begin
        if (obj_match.hit) begin
          status = ST_DUPLICATE;
        end else if (obj_match.full) begin
          status = ST_FULL;
        end else begin
          obj_add = accept;
        end
      end
      CMD_READ: begin
        if (!subj_match.hit || !obj_match.hit) begin
          status = ST_UNKNOWN;
        end else if (subj_level >= obj_level) begin
          grant_read = 1'b1;
        end else begin
          status = ST_DENIED;
        end
      end
      CMD_WRITE: begin
        if (!subj_match.hit || !obj_match.hit) begin
          status = ST_UNKNOWN;
        end else if (subj_level <= obj_level) begin
          grant_write = 1'b1;
        end else begin
          status = ST_DENIED;
        end
      end
      default: begin
        status = ST_UNKNOWN;
      end
    endcase
  end

  // The object value RAM is written at the accept edge, so a following
  // command always reads the updated value without forwarding. A new object
  // starts at zero, which also keeps never-written words out of every read.
  assign ram_we    = obj_add || (accept && grant_write);
  assign ram_re    = accept && grant_read;
  assign ram_addr  = obj_add ? obj_free_idx : obj_hit_idx;
  assign ram_wdata = obj_add ? '0 : ValueW'(in_i.write_value);

  marm_ram #(
    .WIDTH (ValueW),
    .DEPTH (OBJECT_ENTRIES)
  ) u_obj_data_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // The lookup stage advances whenever the result register is free or being
  // drained. The RAM read data is held because no new read is issued until
  // the stage moves.
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;

  always_comb begin
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_comb begin
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= status;
      s1_rd_q     <= grant_read;
    end
    if (s1_move) begin
      out_q.status     <= s1_status_q;
      out_q.read_value <= s1_rd_q ? $signed(ram_rdata) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The single RAM port never sees a write and a read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("object RAM port asked to read and write at once");

  // A command is never taken while the lookup stage holds one that cannot move.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (!s1_valid_q || s1_move))
    else $error("lookup stage overwritten");

  // Anything other than a granted read leaves a zero read value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && !s1_rd_q) |=> (out_q.read_value == '0))
    else $error("nonzero read value without a granted read");

  // A table add is only issued while that table has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (subj_add || obj_add) |-> (subj_add ? !subj_match.full : !obj_match.full))
    else $error("add issued to a full table");

endmodule
